### rtl/core/vos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vos_pkg
// shared types and codes of the valve overlap sequencer
// ----------------------------------------------------------------------------
package vos_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_PSTART = 3'd1,
		PH_RUN    = 3'd2,
		PH_OVER   = 3'd3,
		PH_PSTOP  = 3'd4,
		PH_DONE   = 3'd5
	} phase_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHK,
		ST_OPEN,
		ST_SCAN,
		ST_STOP,
		ST_ACLR
	} seq_state_t;

	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_LOAD  = 3'd1;
	localparam logic [2:0] ACT_START = 3'd2;
	localparam logic [2:0] ACT_ESTOP = 3'd3;
	localparam logic [2:0] ACT_ACLR  = 3'd4;

	localparam logic [2:0] KIND_STATUS = 3'd0;
	localparam logic [2:0] KIND_OPEN   = 3'd1;
	localparam logic [2:0] KIND_CLOSE  = 3'd2;
	localparam logic [2:0] KIND_PSTART = 3'd3;
	localparam logic [2:0] KIND_PSTOP  = 3'd4;

	localparam logic [3:0] NOTE_NONE       = 4'd0;
	localparam logic [3:0] NOTE_BUSY       = 4'd1;
	localparam logic [3:0] NOTE_EMPTY      = 4'd2;
	localparam logic [3:0] NOTE_BAD_STEP   = 4'd3;
	localparam logic [3:0] NOTE_FIRST_FAIL = 4'd4;
	localparam logic [3:0] NOTE_OPEN_FAIL  = 4'd5;
	localparam logic [3:0] NOTE_PUMP_FAIL  = 4'd6;
	localparam logic [3:0] NOTE_TOO_FEW    = 4'd7;
	localparam logic [3:0] NOTE_PUMP_OK    = 4'd8;
	localparam logic [3:0] NOTE_COMPLETE   = 4'd9;
	localparam logic [3:0] NOTE_STOPPED    = 4'd10;
	localparam logic [3:0] NOTE_AUTO_CLOSE = 4'd11;
	localparam logic [3:0] NOTE_STARTED    = 4'd12;

	localparam logic [1:0] REG_PSTART_DLY = 2'd0;
	localparam logic [1:0] REG_PSTOP_DLY  = 2'd1;
	localparam logic [1:0] REG_OVERLAP    = 2'd2;
	localparam logic [1:0] REG_MIN_OPEN   = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  step_slot;
		logic [3:0]  node_number;
		logic [3:0]  valve_number;
		logic [31:0] step_duration;
		logic [5:0]  step_total;
		logic        link_ok;
		logic        pump_ok;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  out_node;
		logic [3:0]  out_valve;
		logic [31:0] out_duration;
		logic [5:0]  current_index;
		logic [5:0]  open_count;
		logic [2:0]  phase;
		logic [3:0]  notice;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  node;
		logic [3:0]  valve;
		logic [31:0] dur;
	} step_t;

	// one valve map operation a cycle; node is zero based
	typedef struct packed {
		logic       set;
		logic       clr;
		logic       clr_all;
		logic [3:0] node;
		logic [3:0] valve;
	} map_op_t;

endpackage

### rtl/core/vos_step_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vos_step_store
// step memory, one write and one registered read port
// ----------------------------------------------------------------------------
module vos_step_store #(
	parameter int STEPS = 32,
	parameter int AW    = 5
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  vos_pkg::step_t wr_data,
	input  logic [AW-1:0]  rd_addr,
	output vos_pkg::step_t rd_data
);

	vos_pkg::step_t mem [STEPS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/core/vos_valve_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vos_valve_map
// open valve bits per node with a running count of open valves
// ----------------------------------------------------------------------------
module vos_valve_map #(
	parameter int NODES  = 4,
	parameter int VALVES = 8,
	parameter int NW     = 2,
	parameter int VW     = 3,
	parameter int CW     = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vos_pkg::map_op_t op,
	output logic            hit,
	output logic [CW-1:0]   count
);

	logic [VALVES-1:0] map_q [NODES];
	logic [CW-1:0]     count_q;
	logic [NW-1:0]     ni;
	logic [VW-1:0]     vi;

	assign ni    = op.node[NW-1:0];
	assign vi    = op.valve[VW-1:0];
	assign hit   = map_q[ni][vi];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++) map_q[n] <= '0;
			count_q <= '0;
		end else if (op.clr_all) begin
			for (int n = 0; n < NODES; n++) map_q[n] <= '0;
			count_q <= '0;
		end else if (op.set) begin
			map_q[ni][vi] <= 1'b1;
			if (!hit) count_q <= count_q + CW'(1);
		end else if (op.clr) begin
			map_q[ni][vi] <= 1'b0;
			if (hit) count_q <= count_q - CW'(1);
		end
	end

endmodule

### rtl/core/valve_overlap_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_overlap_sequencer
// valve and pump sequencer with overlapped valve handover
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the last result of that word has been issued. Results appear at most one per
// cycle on result, each marked by result_strobe for a single cycle, and the
// final one carries last; the receiver has to take every result as it comes.
// A tick passes through the execute state, and through the open state too
// when it opens the next valve at a handover; a load or status-only word
// ends in the execute state, a start then reads one step per cycle in the
// check state and opens the first step, an auto-close clears each valve of
// its node in turn. A shutdown (emergency stop, pump failure, end of run)
// walks every bit of the valve map one per cycle, then stops the pump. The
// sequencer reuses one step memory read port, one timer incrementer with one
// limit compare and one valve map update port throughout.
// ----------------------------------------------------------------------------
module valve_overlap_sequencer #(
	parameter int NODES  = 4,
	parameter int VALVES = 8,
	parameter int STEPS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  vos_pkg::in_item_t   item,
	output logic                result_strobe,
	output vos_pkg::out_item_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int AW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int VW = (VALVES > 1) ? $clog2(VALVES) : 1;
	localparam int CW = $clog2(NODES * VALVES + 1);

	// configuration registers
	logic [31:0] pstart_dly_q, pstop_dly_q, overlap_q;
	logic [5:0]  min_open_q;

	// sequencer state
	vos_pkg::seq_state_t state_q, state_d;
	vos_pkg::phase_e_t   phase_q, phase_d, end_phase_q, end_phase_d;
	logic [31:0]         timer_q, timer_d, timer_inc;
	logic [31:0]         lim;
	logic                lim_hit;
	logic [5:0]          run_index_q, run_index_d, run_total_q, run_total_d;
	logic [5:0]          chk_q, chk_d;
	logic                first_q, first_d;
	logic [NW-1:0]       sn_q, sn_d;
	logic [VW-1:0]       sv_q, sv_d;
	logic                scan_link_q, scan_link_d;
	logic [3:0]          stop_note_q, stop_note_d;
	vos_pkg::in_item_t   in_q;

	// shared resources
	logic                wr_en;
	logic [AW-1:0]       rd_addr;
	vos_pkg::step_t      rd_data, wr_data;
	vos_pkg::map_op_t    op;
	logic                hit;
	logic [CW-1:0]       count;

	// result being issued
	logic        emit, e_last;
	logic [2:0]  e_kind;
	logic [3:0]  e_node, e_valve, e_notice;
	logic [31:0] e_dur;
	vos_pkg::out_item_t res_q;
	logic               strobe_q;

	logic running, step_good, scan_end;

	assign busy      = (state_q != vos_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign running   = (phase_q == vos_pkg::PH_PSTART) || (phase_q == vos_pkg::PH_RUN) ||
	                   (phase_q == vos_pkg::PH_OVER) || (phase_q == vos_pkg::PH_PSTOP);
	// saturating millisecond timer
	assign timer_inc = (timer_q == 32'hFFFF_FFFF) ? timer_q : timer_q + 32'd1;
	assign step_good = (rd_data.node >= 4'd1) && (rd_data.node <= 4'(NODES)) &&
	                   ({1'b0, rd_data.valve} < 5'(VALVES)) && (rd_data.dur != 32'd0);
	assign scan_end  = (sn_q == NW'(NODES - 1)) && (sv_q == VW'(VALVES - 1));
	assign wr_data   = '{node: in_q.node_number, valve: in_q.valve_number,
	                     dur: in_q.step_duration};

	// the one limit the timer is held against in the current phase
	always_comb begin
		unique case (phase_q)
			vos_pkg::PH_PSTART: lim = pstart_dly_q;
			vos_pkg::PH_RUN:    lim = rd_data.dur;
			vos_pkg::PH_OVER:   lim = overlap_q;
			vos_pkg::PH_PSTOP:  lim = pstop_dly_q;
			default:            lim = '0;
		endcase
	end
	assign lim_hit = (timer_inc >= lim);

	vos_step_store #(.STEPS(STEPS), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_q.step_slot[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	vos_valve_map #(.NODES(NODES), .VALVES(VALVES), .NW(NW), .VW(VW), .CW(CW)) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.hit    (hit),
		.count  (count)
	);

	// configuration writes, to be made only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstart_dly_q <= 32'd5000;
			pstop_dly_q  <= 32'd5000;
			overlap_q    <= 32'd3000;
			min_open_q   <= 6'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vos_pkg::REG_PSTART_DLY: pstart_dly_q <= cfg_data;
				vos_pkg::REG_PSTOP_DLY:  pstop_dly_q  <= cfg_data;
				vos_pkg::REG_OVERLAP:    overlap_q    <= cfg_data;
				vos_pkg::REG_MIN_OPEN:   min_open_q   <= cfg_data[5:0];
				default:                 ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vos_pkg::ST_IDLE;
			phase_q     <= vos_pkg::PH_IDLE;
			end_phase_q <= vos_pkg::PH_IDLE;
			timer_q     <= '0;
			run_index_q <= '0;
			run_total_q <= '0;
			chk_q       <= '0;
			first_q     <= 1'b0;
			sn_q        <= '0;
			sv_q        <= '0;
			scan_link_q <= 1'b0;
			stop_note_q <= '0;
			strobe_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			end_phase_q <= end_phase_d;
			timer_q     <= timer_d;
			run_index_q <= run_index_d;
			run_total_q <= run_total_d;
			chk_q       <= chk_d;
			first_q     <= first_d;
			sn_q        <= sn_d;
			sv_q        <= sv_d;
			scan_link_q <= scan_link_d;
			stop_note_q <= stop_note_d;
			strobe_q    <= emit;
		end
	end

	// input word and result payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			in_q <= item;
		end
		if (emit) begin
			res_q.kind          <= e_kind;
			res_q.out_node      <= e_node;
			res_q.out_valve     <= e_valve;
			res_q.out_duration  <= e_dur;
			res_q.current_index <= run_index_d;
			res_q.open_count    <= '0;
			res_q.phase         <= phase_d;
			res_q.notice        <= e_notice;
			res_q.last          <= e_last;
		end
	end

	// open count comes straight from the map: it already holds the update
	// made at the edge that registered this result
	always_comb begin
		result            = res_q;
		result.open_count = 6'(count);
	end
	assign result_strobe = strobe_q;

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		end_phase_d = end_phase_q;
		timer_d     = timer_q;
		run_index_d = run_index_q;
		run_total_d = run_total_q;
		chk_d       = chk_q;
		first_d     = first_q;
		sn_d        = sn_q;
		sv_d        = sv_q;
		scan_link_d = scan_link_q;
		stop_note_d = stop_note_q;
		wr_en       = 1'b0;
		rd_addr     = run_index_q[AW-1:0];
		op          = '{set: 1'b0, clr: 1'b0, clr_all: 1'b0,
		                node: 4'(sn_q), valve: 4'(sv_q)};
		emit        = 1'b0;
		e_last      = 1'b0;
		e_kind      = vos_pkg::KIND_STATUS;
		e_node      = '0;
		e_valve     = '0;
		e_dur       = '0;
		e_notice    = vos_pkg::NOTE_NONE;

		unique case (state_q)
			vos_pkg::ST_IDLE: begin
				// read the running step so a tick sees its duration next cycle
				if (start) state_d = vos_pkg::ST_EXEC;
			end

			vos_pkg::ST_EXEC: begin
				// most words finish here with one status result
				emit    = 1'b1;
				e_last  = 1'b1;
				state_d = vos_pkg::ST_IDLE;
				unique case (in_q.action)
					vos_pkg::ACT_TICK: begin
						timer_d = timer_inc;
						unique case (phase_q)
							vos_pkg::PH_DONE: begin
								phase_d = vos_pkg::PH_IDLE;
								timer_d = '0;
							end
							vos_pkg::PH_PSTART: begin
								if (!lim_hit) begin
									// still waiting
								end else if (9'(count) >= 9'(min_open_q)) begin
									e_kind = vos_pkg::KIND_PSTART;
									if (in_q.pump_ok) begin
										phase_d  = vos_pkg::PH_RUN;
										timer_d  = '0;
										e_notice = vos_pkg::NOTE_PUMP_OK;
									end else begin
										// pump refused: emergency shutdown follows
										e_notice    = vos_pkg::NOTE_PUMP_FAIL;
										e_last      = 1'b0;
										sn_d        = '0;
										sv_d        = '0;
										scan_link_d = in_q.link_ok;
										end_phase_d = vos_pkg::PH_IDLE;
										stop_note_d = vos_pkg::NOTE_STOPPED;
										state_d     = vos_pkg::ST_SCAN;
									end
								end else begin
									// too few open: wait the start delay again
									timer_d  = '0;
									e_notice = vos_pkg::NOTE_TOO_FEW;
								end
							end
							vos_pkg::PH_RUN: begin
								if (run_index_q >= run_total_q) begin
									phase_d = vos_pkg::PH_PSTOP;
									timer_d = '0;
								end else if (lim_hit) begin
									timer_d = '0;
									if (7'(run_index_q) + 7'd1 < 7'(run_total_q)) begin
										// hand over: open the next valve first
										phase_d = vos_pkg::PH_OVER;
										emit    = 1'b0;
										e_last  = 1'b0;
										first_d = 1'b0;
										rd_addr = AW'(run_index_q + 6'd1);
										state_d = vos_pkg::ST_OPEN;
									end else begin
										phase_d = vos_pkg::PH_PSTOP;
									end
								end
							end
							vos_pkg::PH_OVER: begin
								if (lim_hit) begin
									op.node     = rd_data.node - 4'd1;
									op.valve    = rd_data.valve;
									op.clr      = in_q.link_ok;
									run_index_d = run_index_q + 6'd1;
									phase_d     = vos_pkg::PH_RUN;
									timer_d     = '0;
									e_kind      = vos_pkg::KIND_CLOSE;
									e_node      = rd_data.node;
									e_valve     = rd_data.valve;
								end
							end
							vos_pkg::PH_PSTOP: begin
								if (lim_hit) begin
									emit        = 1'b0;
									e_last      = 1'b0;
									sn_d        = '0;
									sv_d        = '0;
									scan_link_d = in_q.link_ok;
									end_phase_d = vos_pkg::PH_DONE;
									stop_note_d = vos_pkg::NOTE_COMPLETE;
									state_d     = vos_pkg::ST_SCAN;
								end
							end
							default: ;
						endcase
					end
					vos_pkg::ACT_LOAD: begin
						if (running) begin
							e_notice = vos_pkg::NOTE_BUSY;
						end else begin
							wr_en = ({4'b0, in_q.step_slot} < 9'(STEPS));
						end
					end
					vos_pkg::ACT_START: begin
						if (running) begin
							e_notice = vos_pkg::NOTE_BUSY;
						end else if (in_q.step_total == 6'd0) begin
							e_notice = vos_pkg::NOTE_EMPTY;
						end else if ({3'b0, in_q.step_total} > 9'(STEPS)) begin
							e_notice = vos_pkg::NOTE_BAD_STEP;
						end else begin
							// walk the steps, one read per cycle
							emit    = 1'b0;
							e_last  = 1'b0;
							chk_d   = '0;
							rd_addr = '0;
							state_d = vos_pkg::ST_CHK;
						end
					end
					vos_pkg::ACT_ESTOP: begin
						if (running) begin
							emit        = 1'b0;
							e_last      = 1'b0;
							sn_d        = '0;
							sv_d        = '0;
							scan_link_d = in_q.link_ok;
							end_phase_d = vos_pkg::PH_IDLE;
							stop_note_d = vos_pkg::NOTE_STOPPED;
							state_d     = vos_pkg::ST_SCAN;
						end
					end
					vos_pkg::ACT_ACLR: begin
						if ((in_q.node_number >= 4'd1) && (in_q.node_number <= 4'(NODES))) begin
							emit    = 1'b0;
							e_last  = 1'b0;
							sn_d    = NW'(in_q.node_number - 4'd1);
							sv_d    = '0;
							state_d = vos_pkg::ST_ACLR;
						end
					end
					default: ;
				endcase
			end

			vos_pkg::ST_CHK: begin
				if (!step_good) begin
					emit     = 1'b1;
					e_last   = 1'b1;
					e_notice = vos_pkg::NOTE_BAD_STEP;
					state_d  = vos_pkg::ST_IDLE;
				end else if (7'(chk_q) + 7'd1 < 7'(in_q.step_total)) begin
					chk_d   = chk_q + 6'd1;
					rd_addr = AW'(chk_q + 6'd1);
				end else begin
					// all steps good: commit the run, then open step zero
					run_total_d = in_q.step_total;
					run_index_d = '0;
					op.clr_all  = 1'b1;
					if (in_q.link_ok) begin
						phase_d = vos_pkg::PH_PSTART;
						timer_d = '0;
					end
					first_d = 1'b1;
					rd_addr = '0;
					state_d = vos_pkg::ST_OPEN;
				end
			end

			vos_pkg::ST_OPEN: begin
				op.node  = rd_data.node - 4'd1;
				op.valve = rd_data.valve;
				op.set   = in_q.link_ok;
				emit     = 1'b1;
				e_last   = 1'b1;
				e_kind   = vos_pkg::KIND_OPEN;
				e_node   = rd_data.node;
				e_valve  = rd_data.valve;
				e_dur    = rd_data.dur;
				if (first_q) begin
					e_notice = in_q.link_ok ? vos_pkg::NOTE_STARTED : vos_pkg::NOTE_FIRST_FAIL;
				end else begin
					e_notice = in_q.link_ok ? vos_pkg::NOTE_NONE : vos_pkg::NOTE_OPEN_FAIL;
				end
				state_d = vos_pkg::ST_IDLE;
			end

			vos_pkg::ST_SCAN: begin
				// one map bit a cycle, a close for each open valve
				if (hit) begin
					op.clr  = scan_link_q;
					emit    = 1'b1;
					e_kind  = vos_pkg::KIND_CLOSE;
					e_node  = 4'(sn_q) + 4'd1;
					e_valve = 4'(sv_q);
				end
				if (scan_end) begin
					state_d = vos_pkg::ST_STOP;
				end else if (sv_q == VW'(VALVES - 1)) begin
					sv_d = '0;
					sn_d = sn_q + NW'(1);
				end else begin
					sv_d = sv_q + VW'(1);
				end
			end

			vos_pkg::ST_STOP: begin
				op.clr_all = 1'b1;
				phase_d    = end_phase_q;
				timer_d    = '0;
				emit       = 1'b1;
				e_last     = 1'b1;
				e_kind     = vos_pkg::KIND_PSTOP;
				e_notice   = stop_note_q;
				state_d    = vos_pkg::ST_IDLE;
			end

			vos_pkg::ST_ACLR: begin
				op.clr = 1'b1;
				if (sv_q == VW'(VALVES - 1)) begin
					emit     = 1'b1;
					e_last   = 1'b1;
					e_notice = vos_pkg::NOTE_AUTO_CLOSE;
					state_d  = vos_pkg::ST_IDLE;
				end else begin
					sv_d = sv_q + VW'(1);
				end
			end

			default: state_d = vos_pkg::ST_IDLE;
		endcase
	end

	// a result only follows a cycle of work
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result issued without a word in progress");

	// the final result of a word coincides with the return to idle
	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> $past(state_d == vos_pkg::ST_IDLE))
		else $error("last result issued while the word is still running");

	// the open count never exceeds the number of valves
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count) <= 32'(NODES * VALVES)))
		else $error("open valve count out of range");

	// a pump stop result always leaves the map empty
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && (result.kind == vos_pkg::KIND_PSTOP)) |-> (count == '0))
		else $error("pump stop with valves still marked open");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the valve overlap sequencer
// ----------------------------------------------------------------------------
// Words are queued by a stimulus process and fed to the block by a clocked
// driver with random gaps, or none while no_gap is set. An in-bench sequencer
// model predicts every result word as each input word is accepted; a clocked
// monitor checks the result words field by field in order. Register settings
// change only while the block is idle: directed corner words first, then runs
// of well-formed step programmes with random content and some noise.
// ----------------------------------------------------------------------------
module tb_top;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	vos_pkg::in_item_t   item = '0;
	logic                result_strobe;
	vos_pkg::out_item_t  result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = vos_pkg::REG_PSTART_DLY;
	logic [31:0]         cfg_data = '0;

	valve_overlap_sequencer uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// ---------------------------------------------------------------- clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50ms;
		$display("** valve_overlap_sequencer: FAILED **");
		$finish;
	end

	// ------------------------------------------------- sequencer model state
	logic [31:0]        c_pstart_dly = 32'd5000;
	logic [31:0]        c_pstop_dly  = 32'd5000;
	logic [31:0]        c_overlap    = 32'd3000;
	logic [5:0]         c_min_open   = 6'd1;
	vos_pkg::phase_e_t  m_phase = vos_pkg::PH_IDLE;
	logic [31:0]        m_timer = '0;
	logic [5:0]         m_idx = '0;
	logic [5:0]         m_tot = '0;
	logic [3:0]         s_node [32];
	logic [3:0]         s_valve [32];
	logic [31:0]        s_dur [32];
	logic [7:0]         vmap [4] = '{default: 8'h00};

	vos_pkg::out_item_t due_q [$];     // result words still to come, oldest first
	vos_pkg::in_item_t  pend_q [$];    // input words waiting for the driver
	int                 n_fail = 0;
	bit                 no_gap = 0;

	function automatic logic [5:0] open_valves();
		logic [5:0] c;
		c = '0;
		for (int n = 0; n < 4; n++)
			for (int v = 0; v < 8; v++)
				c = c + 6'(vmap[n][v]);
		return c;
	endfunction

	function automatic void emit(logic [2:0] kind, logic [3:0] nd, logic [3:0] vl,
			logic [31:0] dur, logic [3:0] note);
		vos_pkg::out_item_t r;
		r.kind = kind;
		r.out_node = nd;
		r.out_valve = vl;
		r.out_duration = dur;
		r.current_index = m_idx;
		r.open_count = open_valves();
		r.phase = m_phase;
		r.notice = note;
		r.last = 1'b0;
		due_q.push_back(r);
	endfunction

	function automatic void enter(vos_pkg::phase_e_t p);
		m_phase = p;
		m_timer = '0;
	endfunction

	function automatic bit step_good(int i);
		return s_node[i] >= 1 && s_node[i] <= 4 && s_valve[i] < 8 && s_dur[i] != 0;
	endfunction

	function automatic void open_step(int i, bit link, logic [3:0] ok_note,
			logic [3:0] bad_note);
		if (link)
			vmap[s_node[i] - 1][s_valve[i][2:0]] = 1'b1;
		emit(vos_pkg::KIND_OPEN, s_node[i], s_valve[i], s_dur[i],
			link ? ok_note : bad_note);
	endfunction

	// closes every marked valve one by one, then stops the pump
	function automatic void shut_all(bit link, vos_pkg::phase_e_t end_ph, logic [3:0] note);
		for (int n = 0; n < 4; n++)
			for (int v = 0; v < 8; v++)
				if (vmap[n][v]) begin
					if (link)
						vmap[n][v] = 1'b0;
					emit(vos_pkg::KIND_CLOSE, 4'(n + 1), 4'(v), '0, vos_pkg::NOTE_NONE);
				end
		vmap = '{default: 8'h00};
		enter(end_ph);
		emit(vos_pkg::KIND_PSTOP, '0, '0, '0, note);
	endfunction

	function automatic bit is_running();
		return m_phase >= vos_pkg::PH_PSTART && m_phase <= vos_pkg::PH_PSTOP;
	endfunction

	function automatic void tick_model(bit link, bit pump);
		int i;
		if (m_timer != 32'hFFFF_FFFF)
			m_timer++;
		case (m_phase)
			vos_pkg::PH_DONE: begin
				enter(vos_pkg::PH_IDLE);
				emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
			end
			vos_pkg::PH_PSTART: begin
				if (m_timer < c_pstart_dly)
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
				else if (open_valves() >= c_min_open) begin
					if (pump) begin
						enter(vos_pkg::PH_RUN);
						emit(vos_pkg::KIND_PSTART, '0, '0, '0, vos_pkg::NOTE_PUMP_OK);
					end else begin
						emit(vos_pkg::KIND_PSTART, '0, '0, '0, vos_pkg::NOTE_PUMP_FAIL);
						shut_all(link, vos_pkg::PH_IDLE, vos_pkg::NOTE_STOPPED);
					end
				end else begin
					// too few open: the start delay begins again
					m_timer = '0;
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_TOO_FEW);
				end
			end
			vos_pkg::PH_RUN: begin
				if (m_idx >= m_tot)
					enter(vos_pkg::PH_PSTOP);
				else if (m_timer >= s_dur[m_idx[4:0]]) begin
					if (m_idx + 1 < m_tot) begin
						enter(vos_pkg::PH_OVER);
						open_step(int'(m_idx[4:0]) + 1, link, vos_pkg::NOTE_NONE,
							vos_pkg::NOTE_OPEN_FAIL);
						return;
					end
					enter(vos_pkg::PH_PSTOP);
				end
				emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
			end
			vos_pkg::PH_OVER: begin
				if (m_timer >= c_overlap) begin
					i = int'(m_idx[4:0]);
					if (link)
						vmap[s_node[i] - 1][s_valve[i][2:0]] = 1'b0;
					m_idx = m_idx + 6'd1;
					enter(vos_pkg::PH_RUN);
					emit(vos_pkg::KIND_CLOSE, s_node[i], s_valve[i], '0, vos_pkg::NOTE_NONE);
				end else
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
			end
			vos_pkg::PH_PSTOP: begin
				if (m_timer >= c_pstop_dly)
					shut_all(link, vos_pkg::PH_DONE, vos_pkg::NOTE_COMPLETE);
				else
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
			end
			default: emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
		endcase
	endfunction

	// expected result words of one accepted input word
	function automatic void predict_results(vos_pkg::in_item_t w);
		bit good;
		case (w.action)
			vos_pkg::ACT_TICK: tick_model(w.link_ok, w.pump_ok);
			vos_pkg::ACT_LOAD: begin
				if (is_running())
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_BUSY);
				else begin
					s_node[w.step_slot] = w.node_number;
					s_valve[w.step_slot] = w.valve_number;
					s_dur[w.step_slot] = w.step_duration;
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
				end
			end
			vos_pkg::ACT_START: begin
				good = w.step_total <= 32;
				for (int i = 0; good && i < w.step_total; i++)
					good = step_good(i);
				if (is_running())
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_BUSY);
				else if (w.step_total == 0)
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_EMPTY);
				else if (!good)
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_BAD_STEP);
				else begin
					m_tot = w.step_total;
					m_idx = '0;
					vmap = '{default: 8'h00};
					if (w.link_ok)
						enter(vos_pkg::PH_PSTART);
					open_step(0, w.link_ok, vos_pkg::NOTE_STARTED, vos_pkg::NOTE_FIRST_FAIL);
				end
			end
			vos_pkg::ACT_ESTOP: begin
				if (is_running())
					shut_all(w.link_ok, vos_pkg::PH_IDLE, vos_pkg::NOTE_STOPPED);
				else
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
			end
			vos_pkg::ACT_ACLR: begin
				if (w.node_number >= 1 && w.node_number <= 4) begin
					vmap[w.node_number - 1] = 8'h00;
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_AUTO_CLOSE);
				end else
					emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
			end
			default: emit(vos_pkg::KIND_STATUS, '0, '0, '0, vos_pkg::NOTE_NONE);
		endcase
		due_q[due_q.size() - 1].last = 1'b1;
	endfunction

	// --------------------------------------------------------------- driver
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				predict_results(item);
			if (!(start && busy)) begin
				if (gap > 0) begin
					gap <= gap - 1;
					start <= 1'b0;
				end else if (pend_q.size() > 0) begin
					item <= pend_q.pop_front();
					start <= 1'b1;
					gap <= no_gap ? 0 : int'($urandom_range(0, 10));
				end else
					start <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------------- monitor
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin
		vos_pkg::out_item_t e;
		if (arst_n && result_strobe) begin
			if (due_q.size() == 0) begin
				$error("result word with none expected");
				n_fail++;
			end else begin
				e = due_q.pop_front();
				check_field("kind", 32'(e.kind), 32'(result.kind));
				check_field("out_node", 32'(e.out_node), 32'(result.out_node));
				check_field("out_valve", 32'(e.out_valve), 32'(result.out_valve));
				check_field("out_duration", e.out_duration, result.out_duration);
				check_field("current_index", 32'(e.current_index), 32'(result.current_index));
				check_field("open_count", 32'(e.open_count), 32'(result.open_count));
				check_field("phase", 32'(e.phase), 32'(result.phase));
				check_field("notice", 32'(e.notice), 32'(result.notice));
				check_field("last", 32'(e.last), 32'(result.last));
			end
		end
	end

	// ------------------------------------------------------------- stimulus
	function automatic vos_pkg::in_item_t word(logic [2:0] act, logic [4:0] slot,
			logic [3:0] nd, logic [3:0] vl, logic [31:0] dur, logic [5:0] tot,
			bit link, bit pump);
		vos_pkg::in_item_t w;
		w.action = act;
		w.step_slot = slot;
		w.node_number = nd;
		w.valve_number = vl;
		w.step_duration = dur;
		w.step_total = tot;
		w.link_ok = link;
		w.pump_ok = pump;
		return w;
	endfunction

	function automatic bit mostly();
		return $urandom_range(0, 9) != 0;
	endfunction

	function automatic vos_pkg::in_item_t noise_word();
		vos_pkg::in_item_t w;
		w = vos_pkg::in_item_t'({$urandom, $urandom});
		w.action = 3'($urandom_range(0, 7));
		return w;
	endfunction

	// wait until the block has drained, then allow for trailing work
	task automatic settle();
		while (pend_q.size() != 0 || start || due_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			vos_pkg::REG_PSTART_DLY: c_pstart_dly = val;
			vos_pkg::REG_PSTOP_DLY:  c_pstop_dly = val;
			vos_pkg::REG_OVERLAP:    c_overlap = val;
			vos_pkg::REG_MIN_OPEN:   c_min_open = val[5:0];
			default:                 ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		settle();
		write_reg(vos_pkg::REG_PSTART_DLY, a);
		write_reg(vos_pkg::REG_PSTOP_DLY, b);
		write_reg(vos_pkg::REG_OVERLAP, c);
		write_reg(vos_pkg::REG_MIN_OPEN, d);
	endtask

	// one step programme: load, start, tick until idle or the tick limit, with optional noise
	task automatic run_programme(int k, bit noisy);
		int n;
		for (int i = 0; i < k; i++)
			pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'(i), 4'($urandom_range(1, 4)),
				4'($urandom_range(0, 7)), $urandom_range(1, 3), '0, mostly(), mostly()));
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'(k), mostly(), mostly()));
		settle();
		n = 0;
		while (m_phase != vos_pkg::PH_IDLE && n < 16) begin
			for (int j = 0; j < 8; j++)
				if (noisy && $urandom_range(0, 7) == 0)
					pend_q.push_back(noise_word());
				else
					pend_q.push_back(word(vos_pkg::ACT_TICK, '0, '0, '0, '0, '0,
						mostly(), mostly()));
			settle();
			n += 8;
		end
		// a run that cannot finish under these settings is stopped
		if (is_running())
			pend_q.push_back(word(vos_pkg::ACT_ESTOP, '0, '0, '0, '0, '0, mostly(), 1'b1));
		if (m_phase == vos_pkg::PH_DONE || is_running())
			pend_q.push_back(word(vos_pkg::ACT_TICK, '0, '0, '0, '0, '0, 1'b1, 1'b1));
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, fast timing
		set_regs(0, 0, 0, 1);
		pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'd0, 4'd1, 4'd0, 32'd1, '0, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'd1, 4'd4, 4'd7, 32'd2, '0, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'd31, 4'd15, 4'd15, 32'hFFFF_FFFF,
			6'd63, 0, 0));
		pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'd2, 4'd0, 4'd8, 32'd0, '0, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd0, 1, 1));  // empty
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd63, 1, 1)); // too many
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd3, 1, 1));  // bad step
		pend_q.push_back(word(3'd5, '0, '0, '0, '0, '0, 1, 1));
		pend_q.push_back(word(3'd6, 5'd31, 4'd15, 4'd15, 32'hFFFF_FFFF, 6'd63, 1, 1));
		pend_q.push_back(word(3'd7, '0, '0, '0, '0, '0, 0, 0));
		pend_q.push_back(word(vos_pkg::ACT_ESTOP, '0, '0, '0, '0, '0, 1, 1));    // while idle
		pend_q.push_back(word(vos_pkg::ACT_ACLR, '0, 4'd0, '0, '0, '0, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_ACLR, '0, 4'd15, '0, '0, '0, 1, 1));
		// first open refused
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd2, 0, 1));
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd2, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'd3, 4'd1, 4'd1, 32'd1, '0, 1, 1)); // busy
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd1, 1, 1));  // busy
		pend_q.push_back(word(vos_pkg::ACT_ACLR, '0, 4'd1, '0, '0, '0, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_TICK, '0, '0, '0, '0, '0, 1, 1));     // too few open
		pend_q.push_back(word(vos_pkg::ACT_ESTOP, '0, '0, '0, '0, '0, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_START, '0, '0, '0, '0, 6'd1, 1, 1));
		pend_q.push_back(word(vos_pkg::ACT_TICK, '0, '0, '0, '0, '0, 1, 0));     // pump refused
		pend_q.push_back(word(vos_pkg::ACT_TICK, '0, '0, '0, '0, '0, 1, 1));
		settle();

		// every slot gets a valid step before any random start
		for (int i = 0; i < 32; i++)
			pend_q.push_back(word(vos_pkg::ACT_LOAD, 5'(i), 4'($urandom_range(1, 4)),
				4'($urandom_range(0, 7)), $urandom_range(1, 4), '0, 1, 1));
		settle();

		set_regs(1, 1, 1, 1);
		run_programme(3, 0);
		no_gap = 1;
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32);
		run_programme(2, 1);
		no_gap = 0;
		set_regs($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
			$urandom_range(0, 2));
		run_programme($urandom_range(1, 6), 1);

		settle();
		if (n_fail == 0)
			$display("** valve_overlap_sequencer: PASSED **");
		else
			$display("** valve_overlap_sequencer: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/core/vos_pkg.sv
rtl/core/vos_step_store.sv
rtl/core/vos_valve_map.sv
rtl/core/valve_overlap_sequencer.sv
verif/tb_top.sv
